@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/xcfv_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfv_pkg
// Types and constants shared by the frame validator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcfv_pkg;

    localparam logic [7:0] START_MARK    = 8'hAA;
    localparam logic [7:0] END_MARK      = 8'h55;
    localparam logic [3:0] MIN_FRAME_LEN = 4'd9;

    typedef enum logic [2:0] {
        VERDICT_OK           = 3'd0,
        VERDICT_TOO_SHORT    = 3'd1,
        VERDICT_BAD_START    = 3'd2,
        VERDICT_BAD_END      = 3'd3,
        VERDICT_BAD_CHECKSUM = 3'd4,
        VERDICT_WRONG_DEVICE = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } in_payload_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  device_type;
        logic [7:0]  device_id;
        logic [7:0]  data_type;
        logic [15:0] payload_length;
    } out_payload_t;

    // classified frame handed from the front end to the back end
    typedef struct packed {
        logic        too_short;
        logic        bad_start;
        logic        bad_end;
        logic        bad_xor;
        logic [7:0]  device_type;
        logic [7:0]  device_id;
        logic [7:0]  data_type;
        logic [15:0] payload_length;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

@@ rtl/xcfv_front.sv @@
// ----------------------------------------------------------------------------
// xcfv_front
// Byte intake: header capture, running XOR, byte count and frame checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfv_front import xcfv_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_payload_t  s_payload,
    input  fifo_status_t fifo_status,
    output logic         push,
    output frame_rec_t   push_rec
);

    logic [3:0]  pos_reg,    pos_next;
    logic [7:0]  xor_reg,    xor_next;
    logic [7:0]  start_reg,  start_next;
    logic [7:0]  dtype_reg,  dtype_next;
    logic [7:0]  did_reg,    did_next;
    logic [7:0]  data_reg,   data_next;
    logic [15:0] len_reg,    len_next;

    logic [7:0]  rec_start, rec_dtype, rec_did, rec_data;
    logic [15:0] rec_len;
    logic [3:0]  total;
    logic        accept;

    assign s_ready = !fifo_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // header with the current byte recorded at its position
        rec_start = start_reg;
        rec_dtype = dtype_reg;
        rec_did   = did_reg;
        rec_data  = data_reg;
        rec_len   = len_reg;
        unique case (pos_reg)
            4'd0:    rec_start     = s_payload.frame_byte;
            4'd1:    rec_dtype     = s_payload.frame_byte;
            4'd2:    rec_did       = s_payload.frame_byte;
            4'd3:    rec_data      = s_payload.frame_byte;
            4'd4:    rec_len[7:0]  = s_payload.frame_byte;
            4'd5:    rec_len[15:8] = s_payload.frame_byte;
            default: ;
        endcase

        total = (pos_reg < MIN_FRAME_LEN) ? pos_reg + 4'd1 : MIN_FRAME_LEN;

        push_rec.too_short      = total < MIN_FRAME_LEN;
        push_rec.bad_start      = rec_start != START_MARK;
        push_rec.bad_end        = s_payload.frame_byte != END_MARK;
        push_rec.bad_xor        = xor_reg != 8'd0;
        push_rec.device_type    = rec_dtype;
        push_rec.device_id      = rec_did;
        push_rec.data_type      = rec_data;
        push_rec.payload_length = rec_len;

        push       = accept && s_payload.end_of_frame;

        pos_next   = pos_reg;
        xor_next   = xor_reg;
        start_next = start_reg;
        dtype_next = dtype_reg;
        did_next   = did_reg;
        data_next  = data_reg;
        len_next   = len_reg;
        if (accept) begin
            if (s_payload.end_of_frame) begin
                pos_next   = 4'd0;
                xor_next   = 8'd0;
                start_next = 8'd0;
                dtype_next = 8'd0;
                did_next   = 8'd0;
                data_next  = 8'd0;
                len_next   = 16'd0;
            end else begin
                pos_next   = total;
                xor_next   = xor_reg ^ s_payload.frame_byte;
                start_next = rec_start;
                dtype_next = rec_dtype;
                did_next   = rec_did;
                data_next  = rec_data;
                len_next   = rec_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 4'd0;
            xor_reg   <= 8'd0;
            start_reg <= 8'd0;
            dtype_reg <= 8'd0;
            did_reg   <= 8'd0;
            data_reg  <= 8'd0;
            len_reg   <= 16'd0;
        end else begin
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            start_reg <= start_next;
            dtype_reg <= dtype_next;
            did_reg   <= did_next;
            data_reg  <= data_next;
            len_reg   <= len_next;
        end
    end

endmodule

@@ rtl/xcfv_fifo.sv @@
// ----------------------------------------------------------------------------
// xcfv_fifo
// Short queue of classified frames between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfv_fifo import xcfv_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  frame_rec_t   push_rec,
    input  logic         pop,
    output frame_rec_t   pop_rec,
    output fifo_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_rec_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push, do_pop;

    assign status.full  = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_rec      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

@@ rtl/xcfv_back.sv @@
// ----------------------------------------------------------------------------
// xcfv_back
// Verdict priority encode and result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfv_back import xcfv_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  fifo_status_t fifo_status,
    input  frame_rec_t   pop_rec,
    output logic         pop,
    input  logic [7:0]   expected_type,
    output logic         m_valid,
    input  logic         m_ready,
    output out_payload_t m_payload
);

    logic         valid_reg, valid_next;
    out_payload_t out_reg;
    verdict_t     verdict;

    assign pop       = !fifo_status.empty && (!valid_reg || m_ready);
    assign m_valid   = valid_reg;
    assign m_payload = out_reg;

    // first failing check wins
    always_comb begin
        if (pop_rec.too_short) begin
            verdict = VERDICT_TOO_SHORT;
        end else if (pop_rec.bad_start) begin
            verdict = VERDICT_BAD_START;
        end else if (pop_rec.bad_end) begin
            verdict = VERDICT_BAD_END;
        end else if (pop_rec.bad_xor) begin
            verdict = VERDICT_BAD_CHECKSUM;
        end else if (pop_rec.device_type != expected_type) begin
            verdict = VERDICT_WRONG_DEVICE;
        end else begin
            verdict = VERDICT_OK;
        end

        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg.verdict        <= verdict;
            out_reg.device_type    <= pop_rec.device_type;
            out_reg.device_id      <= pop_rec.device_id;
            out_reg.data_type      <= pop_rec.data_type;
            out_reg.payload_length <= pop_rec.payload_length;
        end
    end

endmodule

@@ rtl/xor_checked_frame_validator_unit.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_validator_unit
// Takes one frame byte per cycle on s_ and gives one verdict per frame on m_.
// A byte is taken every cycle while the frame queue (QUEUE_DEPTH entries) has
// room; bytes that are not the last never stall once a slot is free. The
// verdict and header fields reach m_ through the queue and the output
// register once the last byte is taken, so a downstream stall only backs
// up into the input once the queue is full. The checks in order: at
// least 9 bytes, start byte 0xAA, last byte 0x55, XOR of all bytes before the
// last is zero, device type equals the value written on cfg_.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module xor_checked_frame_validator_unit import xcfv_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  in_payload_t  s_payload,
    output logic         m_valid,
    input  logic         m_ready,
    output out_payload_t m_payload,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);

    logic [7:0]   expected_type_reg;
    logic         push, pop;
    frame_rec_t   push_rec, pop_rec;
    fifo_status_t fifo_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_type_reg <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            expected_type_reg <= cfg_data;
        end
    end

    xcfv_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .fifo_status (fifo_status),
        .push        (push),
        .push_rec    (push_rec)
    );

    xcfv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .status   (fifo_status)
    );

    xcfv_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fifo_status   (fifo_status),
        .pop_rec       (pop_rec),
        .pop           (pop),
        .expected_type (expected_type_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload     (m_payload)
    );

    // every accepted byte with the end flag lands in the queue, and only those
    `ASSERT_SAME(a_push_on_last, aclk, aresetn, s_valid && s_ready, push == s_payload.end_of_frame)
    // a push never meets a full queue
    `ASSERT_SAME(a_no_overflow, aclk, aresetn, push, !fifo_status.full)
    // a popped frame shows up on the output next cycle
    `ASSERT_NEXT(a_pop_to_out, aclk, aresetn, pop, m_valid)
    // a pass verdict carries the configured device type
    `ASSERT_SAME(a_ok_type, aclk, aresetn, m_valid && (m_payload.verdict == VERDICT_OK), m_payload.device_type == expected_type_reg)

endmodule

@@ dv/xor_checked_frame_validator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_validator_unit_tb
// Streams byte frames into the validator and checks each verdict it returns.
// A local frame model tracks header capture, the running XOR and the byte
// count, and queues the expected verdict as each last byte is taken. Frames
// are mostly well formed with random content. The rest are short frames,
// frames with a bad start, end or checksum, wrong device types and random
// noise. Both sides idle at random, and the device type register is changed
// between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_checked_frame_validator_unit_tb import xcfv_pkg::*;;

    localparam int CYCLE_LIMIT = 200000;

    typedef logic [7:0] byte_list_t[$];

    typedef enum int {
        FLAW_NONE,
        FLAW_SHORT,
        FLAW_START,
        FLAW_END,
        FLAW_SUM
    } frame_flaw_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    in_payload_t  s_payload = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    out_payload_t m_payload;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_data = 8'h00;

    xor_checked_frame_validator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expectations
    in_payload_t  byte_queue[$];
    out_payload_t pending_verdicts[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           byte_taken = 1'b0;
    bit           src_gaps = 1'b0;
    bit           sink_stalls = 1'b0;
    int           gap_left = 0;
    int           stall_left = 0;

    // frame model state
    logic [7:0]   exp_device_type = 8'h00;
    logic [3:0]   frame_pos = '0;
    logic [7:0]   frame_xor = '0;
    logic [7:0]   got_start = '0;
    logic [7:0]   got_dev_type = '0;
    logic [7:0]   got_dev_id = '0;
    logic [7:0]   got_data_type = '0;
    logic [15:0]  got_length = '0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    task automatic predict_frame_byte(input in_payload_t req);
        out_payload_t rec;
        logic [3:0]   seen;
        case (frame_pos)
            4'd0: got_start = req.frame_byte;
            4'd1: got_dev_type = req.frame_byte;
            4'd2: got_dev_id = req.frame_byte;
            4'd3: got_data_type = req.frame_byte;
            4'd4: got_length[7:0] = req.frame_byte;
            4'd5: got_length[15:8] = req.frame_byte;
            default: ;
        endcase
        seen = (frame_pos < MIN_FRAME_LEN) ? frame_pos + 4'd1 : MIN_FRAME_LEN;
        if (!req.end_of_frame) begin
            frame_pos = seen;
            frame_xor = frame_xor ^ req.frame_byte;
        end else begin
            // frame_xor covers every byte but the last, so a good checksum leaves it zero
            if (seen < MIN_FRAME_LEN)
                rec.verdict = VERDICT_TOO_SHORT;
            else if (got_start != START_MARK)
                rec.verdict = VERDICT_BAD_START;
            else if (req.frame_byte != END_MARK)
                rec.verdict = VERDICT_BAD_END;
            else if (frame_xor != 8'h00)
                rec.verdict = VERDICT_BAD_CHECKSUM;
            else if (got_dev_type != exp_device_type)
                rec.verdict = VERDICT_WRONG_DEVICE;
            else
                rec.verdict = VERDICT_OK;
            rec.device_type    = got_dev_type;
            rec.device_id      = got_dev_id;
            rec.data_type      = got_data_type;
            rec.payload_length = got_length;
            pending_verdicts.push_back(rec);
            frame_pos     = '0;
            frame_xor     = '0;
            got_start     = '0;
            got_dev_type  = '0;
            got_dev_id    = '0;
            got_data_type = '0;
            got_length    = '0;
        end
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            mismatches++;
        end
    endtask

    task automatic check_verdict(input out_payload_t got);
        out_payload_t want;
        if (pending_verdicts.size() == 0) begin
            $error("verdict %0d with no frame outstanding", got.verdict);
            mismatches++;
        end else begin
            want = pending_verdicts.pop_front();
            check_field("verdict", want.verdict, got.verdict);
            check_field("device_type", want.device_type, got.device_type);
            check_field("device_id", want.device_id, got.device_id);
            check_field("data_type", want.data_type, got.data_type);
            check_field("payload_length", want.payload_length, got.payload_length);
        end
    endtask

    // monitor: register writes, results, then accepted bytes
    always @(posedge aclk) begin
        if (!aresetn) begin
            byte_taken = 1'b0;
        end else begin
            byte_taken = s_valid && s_ready;
            if (cfg_valid && cfg_ready)
                exp_device_type = cfg_data;
            if (m_valid && m_ready)
                check_verdict(m_payload);
            if (byte_taken)
                predict_frame_byte(s_payload);
        end
    end

    // byte driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !byte_taken) begin
            // hold the request until it is taken
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (byte_queue.size() != 0) begin
            s_valid   <= 1'b1;
            s_payload <= byte_queue.pop_front();
            gap_left = pick_gap(src_gaps);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result sink back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap(sink_stalls);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic queue_bytes(input byte_list_t frame);
        in_payload_t req;
        for (int i = 0; i < frame.size(); i++) begin
            req.frame_byte   = frame[i];
            req.end_of_frame = (i == frame.size() - 1);
            byte_queue.push_back(req);
        end
    endtask

    // header, body_len payload bytes, checksum, end mark; one flaw at most
    task automatic queue_frame(input logic [7:0] dev_type, input int body_len,
                               input frame_flaw_t flaw);
        byte_list_t frame;
        logic [7:0] sum;
        int         cut;
        frame = {};
        frame.push_back(flaw == FLAW_START ?
                        START_MARK ^ 8'($urandom_range(1, 255)) : START_MARK);
        frame.push_back(dev_type);
        for (int i = 0; i < 4 + body_len; i++)
            frame.push_back(8'($urandom));
        sum = '0;
        foreach (frame[i])
            sum = sum ^ frame[i];
        frame.push_back(flaw == FLAW_SUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
        frame.push_back(flaw == FLAW_END ?
                        END_MARK ^ 8'($urandom_range(1, 255)) : END_MARK);
        if (flaw == FLAW_SHORT) begin
            cut = $urandom_range(1, 8);
            while (frame.size() > cut)
                void'(frame.pop_back());
        end
        queue_bytes(frame);
    endtask

    task automatic write_device_type(input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || s_valid || pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_phase(input logic [7:0] dev_cfg, input bit src_idle,
                                input bit sink_idle, input int budget);
        int          added;
        int          roll;
        int          body;
        logic [7:0]  dev;
        frame_flaw_t flaw;
        byte_list_t  noise;
        write_device_type(dev_cfg);
        src_gaps    = src_idle;
        sink_stalls = sink_idle;
        added = 0;
        while (added < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                noise = {};
                repeat ($urandom_range(1, 14))
                    noise.push_back(8'($urandom));
                queue_bytes(noise);
                added += noise.size();
            end else begin
                if (roll < 70)      flaw = FLAW_NONE;
                else if (roll < 78) flaw = FLAW_SHORT;
                else if (roll < 85) flaw = FLAW_START;
                else if (roll < 92) flaw = FLAW_END;
                else                flaw = FLAW_SUM;
                body = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                    : $urandom_range(9, 30);
                dev  = ($urandom_range(0, 99) < 80) ? dev_cfg : 8'($urandom);
                queue_frame(dev, body, flaw);
                added += 8 + body;
            end
        end
        wait_drained();
    endtask

    initial begin
        byte_list_t frame;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed frames against the reset device type (zero)
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        frame = {END_MARK};
        queue_bytes(frame);
        frame = {START_MARK, 8'h7E};
        queue_bytes(frame);
        frame = {START_MARK, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, END_MARK};
        queue_bytes(frame);
        // all-zero header with a correct checksum: accepted
        frame = {START_MARK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, START_MARK, END_MARK};
        queue_bytes(frame);
        // all-ones header, checksum good, device type differs from zero
        frame = {START_MARK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, START_MARK, END_MARK};
        queue_bytes(frame);
        queue_frame(8'h00, 1, FLAW_START);
        queue_frame(8'h00, 1, FLAW_END);
        queue_frame(8'h00, 1, FLAW_SUM);
        // long frame runs the byte count well past saturation
        queue_frame(8'h00, 25, FLAW_NONE);
        wait_drained();

        random_phase(8'hFF, 1'b0, 1'b0, 80);
        random_phase(8'($urandom), 1'b1, 1'b1, 80);
        random_phase(8'h00, 1'b0, 1'b1, 80);
        random_phase(8'($urandom), 1'b1, 1'b0, 80);

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (pending_verdicts.size() != 0)
                $error("%0d verdicts never arrived", pending_verdicts.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
